FILE: src/sttsg_pkg.sv
// Package for the trapezoid step generator: mode codes, register indexes,
// controller command and status structs. No dependencies.
`default_nettype none
package sttsg_pkg;
  localparam logic [2:0] MODE_TICK = 3'd0;
  localparam logic [2:0] MODE_MOVE = 3'd1;
  localparam logic [2:0] MODE_HOME = 3'd2;
  localparam logic [2:0] MODE_STOP = 3'd3;
  localparam logic [2:0] MODE_SETPOS = 3'd4;

  localparam logic [1:0] REG_SPR = 2'd0;
  localparam logic [1:0] REG_CRUISE = 2'd1;
  localparam logic [1:0] REG_START = 2'd2;
  localparam logic [1:0] REG_ACCEL = 2'd3;

  localparam logic [31:0] HALF_NUM = 32'd30000000;
  localparam logic [31:0] ALL_ONES = 32'hFFFFFFFF;

  // datapath operation selected by the controller
  typedef enum logic [3:0] {
    OP_LOAD      = 4'd0,   // latch input item
    OP_DIV_CH    = 4'd1,   // start divide for cruise half (move/home rpm)
    OP_DIV_SH    = 4'd2,   // start divide for start half
    OP_TICK      = 4'd3,   // apply tick step
    OP_PHASE     = 4'd4,   // work out ramp phase from the stepped count
    OP_MUL       = 4'd5,   // ramp numerator multiply
    OP_RAMP      = 4'd6,   // start ramp divide
    OP_RAMP_DONE = 4'd7,   // take ramp quotient
    OP_MOVE      = 4'd8,   // commit move
    OP_HOME      = 4'd9,   // commit homing
    OP_SIMPLE    = 4'd10,  // stop / set position / unused
    OP_OUT       = 4'd11,  // build result
    OP_NONE      = 4'd12
  } op_t;

  typedef struct packed {
    op_t  op;
    logic div_start;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic [2:0] mode;
    logic tick_needs_ramp;
  } stat_t;
endpackage
`default_nettype wire

FILE: src/sttsg_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, shared by the
// half-period and ramp divides. Depends on sttsg_pkg.
`default_nettype none
module sttsg_div
  import sttsg_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  input  wire  [31:0] dividend,
  input  wire  [31:0] divisor,
  output logic        busy,
  output logic [31:0] quotient
);
  logic [31:0] dvd, dvs;
  logic [31:0] rem;
  logic [5:0]  cnt;
  logic [32:0] shifted;
  logic [33:0] trial;

  assign shifted = {rem, dvd[31]};
  assign trial = {1'b0, shifted} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 6'd32;
      dvd  <= dividend;
      dvs  <= divisor;
      rem  <= '0;
      quotient <= '0;
    end else if (busy) begin
      if (trial[33]) begin
        rem <= shifted[31:0];
        quotient <= {quotient[30:0], 1'b0};
      end else begin
        rem <= trial[31:0];
        quotient <= {quotient[30:0], 1'b1};
      end
      dvd <= {dvd[30:0], 1'b0};
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) busy <= 1'b0;
    end
  end
endmodule
`default_nettype wire

FILE: src/sttsg_ctrl.sv
// Controller state machine of the step generator: sequences load, divides
// and commit per item. Depends on sttsg_pkg.
`default_nettype none
module sttsg_ctrl
  import sttsg_pkg::*;
(
  input  wire   clk,
  input  wire   rst,
  input  wire   in_fire,
  input  wire   out_busy,
  input  stat_t st,
  output cmd_t  cmd,
  output logic  idle
);
  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DECODE = 9'b000000010,
    S_WCH    = 9'b000000100,
    S_WSH    = 9'b000001000,
    S_PHASE  = 9'b000010000,
    S_CHECK  = 9'b000100000,
    S_DIVR   = 9'b001000000,
    S_WRAMP  = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;
  state_t state, state_next;

  assign idle = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op = OP_NONE;
    cmd.div_start = 1'b0;
    unique case (state)
      S_IDLE: if (in_fire) begin
        cmd.op = OP_LOAD;
        state_next = S_DECODE;
      end
      S_DECODE: begin
        if (st.mode == MODE_MOVE || st.mode == MODE_HOME) begin
          cmd.op = OP_DIV_CH;
          cmd.div_start = 1'b1;
          state_next = S_WCH;
        end else if (st.mode == MODE_TICK) begin
          cmd.op = OP_TICK;
          state_next = S_PHASE;
        end else begin
          cmd.op = OP_SIMPLE;
          state_next = S_OUT;
        end
      end
      S_WCH: if (!st.div_busy) begin
        if (st.mode == MODE_MOVE) begin
          cmd.op = OP_DIV_SH;
          cmd.div_start = 1'b1;
          state_next = S_WSH;
        end else begin
          cmd.op = OP_HOME;
          state_next = S_OUT;
        end
      end
      S_WSH: if (!st.div_busy) begin
        cmd.op = OP_MOVE;
        state_next = S_OUT;
      end
      S_PHASE: begin
        cmd.op = OP_PHASE;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        // multiply only when the tick lands inside a ramp
        if (st.tick_needs_ramp) begin
          cmd.op = OP_MUL;
          state_next = S_DIVR;
        end else state_next = S_OUT;
      end
      S_DIVR: begin
        cmd.op = OP_RAMP;
        cmd.div_start = 1'b1;
        state_next = S_WRAMP;
      end
      S_WRAMP: if (!st.div_busy) begin
        cmd.op = OP_RAMP_DONE;
        state_next = S_OUT;
      end
      S_OUT: if (!out_busy) begin
        cmd.op = OP_OUT;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule
`default_nettype wire

FILE: src/sttsg_dp.sv
// Datapath of the step generator: motion state, configuration registers,
// shared divider and ramp multiplier. Depends on sttsg_pkg, sttsg_div.
`default_nettype none
module sttsg_dp
  import sttsg_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  cmd_t        cmd,
  output stat_t       st,
  input  wire         cfg_fire,
  input  wire  [1:0]  cfg_idx,
  input  wire  [31:0] cfg_data,
  input  wire  [2:0]  in_mode,
  input  wire  [31:0] in_target,
  input  wire  [15:0] in_rpm,
  input  wire         in_fwd,
  output logic [71:0] res
);
  logic [15:0] spr, cruise_rpm, base_rpm;
  logic [31:0] accel;
  logic [2:0]  mode;
  logic [31:0] target;
  logic [15:0] rpm;
  logic        fwd_in;
  logic [31:0] pos, done, total, chalf, shalf, ramp, ahalf;
  logic        fwd, homing, moving, enable, armed;
  logic        pulse, at_tgt, rej;
  logic [31:0] ch_res, prod, r_reg, diff, phase_r;
  logic        ch_ones, ramp_need, arm_pend;
  // divider
  logic [31:0] div_a, div_b, div_q, div_half;
  logic        div_busy;
  logic [31:0] div_prod;
  logic [15:0] div_rpm;
  logic        div_ones_now;
  // tick path values
  logic [31:0] done_inc, half_tot, r_n, left_n, phase_n;
  logic [31:0] delta, mag;

  sttsg_div u_div (.clk(clk), .rst(rst), .start(cmd.div_start), .dividend(div_a),
                   .divisor(div_b), .busy(div_busy), .quotient(div_q));

  assign div_rpm = (cmd.op == OP_DIV_SH) ? base_rpm :
                   (mode == MODE_MOVE && rpm == 16'd0) ? cruise_rpm : rpm;
  assign div_prod = {16'd0, div_rpm} * {16'd0, spr};
  always_comb begin
    div_a = HALF_NUM;
    div_b = div_prod;
    if (cmd.op == OP_RAMP) begin
      div_a = prod;
      div_b = r_reg;
    end
  end
  assign div_ones_now = (div_rpm == 16'd0) || (div_prod == 32'd0);
  assign div_half = ch_ones ? ALL_ONES : div_q;

  assign done_inc = done + 32'd1;
  assign half_tot = {1'b0, total[31:1]};
  assign r_n = (ramp < half_tot) ? ramp : half_tot;
  assign left_n = total - done;
  assign phase_n = (done < r_n) ? done : (left_n < r_n) ? left_n : r_n;

  assign delta = target - pos;
  assign mag = delta[31] ? (32'd0 - delta) : delta;

  assign st.div_busy = div_busy;
  assign st.mode = mode;
  assign st.tick_needs_ramp = ramp_need;

  always_ff @(posedge clk) begin
    if (rst) begin
      spr <= 16'd200; cruise_rpm <= 16'd300; base_rpm <= 16'd60; accel <= 32'd400;
      pos <= '0; done <= '0; total <= '0; chalf <= '0; shalf <= '0; ramp <= '0;
      ahalf <= '0; fwd <= 1'b0; homing <= 1'b0; moving <= 1'b0; enable <= 1'b0;
      armed <= 1'b0; ramp_need <= 1'b0; ch_ones <= 1'b0; arm_pend <= 1'b0;
    end else begin
      if (cfg_fire) begin
        unique case (cfg_idx)
          REG_SPR:    spr <= cfg_data[15:0];
          REG_CRUISE: cruise_rpm <= cfg_data[15:0];
          REG_START:  base_rpm <= cfg_data[15:0];
          REG_ACCEL:  accel <= cfg_data;
          default: ;
        endcase
      end
      case (cmd.op)
        OP_LOAD: begin
          mode <= in_mode; target <= in_target; rpm <= in_rpm; fwd_in <= in_fwd;
          pulse <= 1'b0; at_tgt <= 1'b0; rej <= 1'b0; ramp_need <= 1'b0;
          arm_pend <= 1'b0;
        end
        OP_DIV_CH: ch_ones <= div_ones_now;
        OP_DIV_SH: begin
          ch_res <= div_half;
          ch_ones <= div_ones_now;
        end
        OP_HOME: begin
          fwd <= fwd_in; homing <= 1'b1; total <= ALL_ONES; done <= '0;
          chalf <= div_half;
          shalf <= div_half;
          ramp <= '0; enable <= 1'b1; moving <= 1'b1; armed <= 1'b1;
          ahalf <= div_half;
        end
        OP_MOVE: begin
          if (delta == 32'd0) at_tgt <= !moving;
          else if (moving) begin
            if (!delta[31] != fwd) rej <= 1'b1;
            else begin
              chalf <= ch_res; total <= mag;
            end
          end else begin
            total <= mag; fwd <= !delta[31]; homing <= 1'b0; done <= '0;
            chalf <= ch_res;
            shalf <= div_half;
            ramp <= accel; enable <= 1'b1; moving <= 1'b1; armed <= 1'b1;
            ahalf <= div_half;
          end
        end
        OP_TICK: if (moving) begin
          pulse <= 1'b1;
          pos <= fwd ? pos + 32'd1 : pos - 32'd1;
          done <= done_inc;
          if (!homing && done_inc >= total) begin
            moving <= 1'b0; armed <= 1'b0;
          end else arm_pend <= 1'b1;
        end
        OP_PHASE: if (arm_pend) begin
          if (homing || ramp == 32'd0 || phase_n >= r_n || shalf <= chalf) begin
            ahalf <= chalf;
          end else begin
            diff <= shalf - chalf;
            phase_r <= phase_n;
            r_reg <= r_n;
            ramp_need <= 1'b1;
          end
        end
        OP_MUL: prod <= diff * phase_r;
        OP_RAMP_DONE: ahalf <= shalf - div_q;
        OP_SIMPLE: begin
          if (mode == MODE_STOP) begin
            moving <= 1'b0; homing <= 1'b0; armed <= 1'b0;
          end else if (mode == MODE_SETPOS) pos <= target;
        end
        default: ;
      endcase
    end
  end

  // pack: step_pulse, direction, position, moving, homing, alarm_armed,
  // half_period_us, driver_enable, at_target, rejected
  assign res = {rej, at_tgt, enable, (armed ? ahalf : 32'd0), armed, homing, moving,
                pos, fwd, pulse};
endmodule
`default_nettype wire

FILE: src/stepper_trapezoid_step_generator.sv
// Stepper step generator with a trapezoidal ramp in the period domain.
// Channels: s_axis (tuser = mode, tdata = target/rpm/home_forward), cfg
// write channel (cfg_index, cfg_data), m_axis (tdata = status result).
// Each s_axis transaction gives exactly one result. Stop, set position and
// unused modes go from load straight to the result; a tick that needs no
// ramp divide steps, works out its ramp phase and checks it; a tick
// inside a ramp adds a multiply and then a ramp divide; homing adds one
// rpm-to-half-period divide and a move two such divides. All divides use
// the shared iterative divider, one quotient bit per cycle.
// One item is in work at a time; s_axis_tready and cfg_ready are high only
// while the controller is idle, and it is idle again from the cycle in which
// the result is first presented. The result sits in an output register: while
// the receiver stalls m_axis_tready, the register holds and the next item
// is finished up to the point of writing its result.
// Reset (rst, synchronous) restores the register defaults
// (200, 300, 60, 400) and clears all motion state.
`default_nettype none
module stepper_trapezoid_step_generator
  import sttsg_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: target_steps[31:0], rpm[47:32], home_forward[48], zeros
  input  wire  [55:0] s_axis_tdata,
  // tuser: mode[2:0]
  input  wire  [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // tdata: step_pulse[0], direction[1], position[33:2], moving[34],
  // homing[35], alarm_armed[36], half_period_us[68:37], driver_enable[69],
  // at_target[70], rejected[71]
  output logic [71:0] m_axis_tdata,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [31:0] cfg_data
);
  cmd_t  cmd;
  stat_t st;
  logic  idle;
  logic [71:0] res;

  assign s_axis_tready = idle;
  assign cfg_ready = idle;

  sttsg_ctrl u_ctrl (.clk(clk), .rst(rst), .in_fire(s_axis_tvalid && s_axis_tready),
                     .out_busy(m_axis_tvalid && !m_axis_tready), .st(st), .cmd(cmd),
                     .idle(idle));

  sttsg_dp u_dp (.clk(clk), .rst(rst), .cmd(cmd), .st(st),
                 .cfg_fire(cfg_valid && cfg_ready), .cfg_idx(cfg_index), .cfg_data(cfg_data),
                 .in_mode(s_axis_tuser), .in_target(s_axis_tdata[31:0]),
                 .in_rpm(s_axis_tdata[47:32]), .in_fwd(s_axis_tdata[48]), .res(res));

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (cmd.op == OP_OUT) begin
      m_axis_tvalid <= 1'b1;
      m_axis_tdata <= res;
    end else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end
endmodule
`default_nettype wire

FILE: tb/tb_stepper_trapezoid_step_generator.sv
// Testbench for the trapezoid step generator: directed table then random moves, homing,
// ticks, stops, set-position and unused-mode items, each result checked against an in-bench status predictor.
// Depends on sttsg_pkg and the step generator RTL.
`timescale 1ns / 100ps
module tb_stepper_trapezoid_step_generator
  import sttsg_pkg::*;
();

  typedef struct packed {
    logic        rejected;
    logic        at_target;
    logic        driver_enable;
    logic [31:0] half_period_us;
    logic        alarm_armed;
    logic        homing;
    logic        moving;
    logic [31:0] position;
    logic        direction;
    logic        step_pulse;
  } status_t;

  typedef struct {
    logic [2:0]  mode;
    logic [31:0] target;
    logic [15:0] rpm;
    logic        fwd;
    logic        known;
    status_t     res;
  } row_t;

  logic clk = 1'b0, rst = 1'b1;
  logic s_axis_tvalid = 1'b0, m_axis_tready = 1'b0, cfg_valid = 1'b0;
  logic [55:0] s_axis_tdata = '0;
  logic [2:0] s_axis_tuser = '0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  wire s_axis_tready, m_axis_tvalid, cfg_ready;
  wire [71:0] m_axis_tdata;

  stepper_trapezoid_step_generator dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [31:0] spr, cruise_rpm, base_rpm_r, accel;
  logic [31:0] pos, done_n, total_n, ch, sh, ramp, armed_half;
  logic fwd_r, homing_r, moving_r, en_r, armed_r;
  status_t expected_status[$];
  int errors = 0;
  bit stall_rx = 1'b0;

  function automatic logic [31:0] half_of(input logic [31:0] r);
    logic [31:0] d;
    if (r == 0) return ALL_ONES;
    d = r * spr;
    if (d == 0) return ALL_ONES;
    return HALF_NUM / d;
  endfunction

  function automatic logic [31:0] ramp_half();
    logic [31:0] r, left, ph, d;
    if (homing_r || ramp == 0) return ch;
    r = (ramp < total_n / 32'd2) ? ramp : total_n / 32'd2;
    left = total_n - done_n;
    ph = (done_n < r) ? done_n : (left < r) ? left : r;
    if (ph >= r) return ch;
    if (sh <= ch) return ch;
    d = ((sh - ch) * ph) / r;
    return sh - d;
  endfunction

  task automatic predict_status(input logic [2:0] m, input logic [31:0] tg,
                                input logic [15:0] rp, input logic hf);
    status_t s;
    logic [31:0] delta, mag, h;
    logic nf;
    s = '0;
    case (m)
      MODE_TICK: if (moving_r) begin
        s.step_pulse = 1'b1;
        pos = fwd_r ? pos + 32'd1 : pos - 32'd1;
        done_n = done_n + 32'd1;
        if (!homing_r && done_n >= total_n) begin
          moving_r = 1'b0; armed_r = 1'b0;
        end else armed_half = ramp_half();
      end
      MODE_MOVE: begin
        delta = tg - pos;
        if (delta == 0) s.at_target = !moving_r;
        else begin
          nf = !delta[31];
          mag = delta[31] ? 32'd0 - delta : delta;
          h = half_of(rp != 16'd0 ? {16'd0, rp} : cruise_rpm);
          if (moving_r) begin
            if (nf != fwd_r) s.rejected = 1'b1;
            else begin ch = h; total_n = mag; end
          end else begin
            total_n = mag; fwd_r = nf; homing_r = 1'b0; done_n = '0; ch = h;
            sh = half_of(base_rpm_r); ramp = accel; en_r = 1'b1;
            moving_r = 1'b1; armed_r = 1'b1; armed_half = sh;
          end
        end
      end
      MODE_HOME: begin
        fwd_r = hf; homing_r = 1'b1; total_n = ALL_ONES; done_n = '0;
        ch = half_of({16'd0, rp}); sh = ch; ramp = '0; en_r = 1'b1;
        moving_r = 1'b1; armed_r = 1'b1; armed_half = ch;
      end
      MODE_STOP: begin moving_r = 1'b0; homing_r = 1'b0; armed_r = 1'b0; end
      MODE_SETPOS: pos = tg;
      default: ;
    endcase
    s.direction = fwd_r; s.position = pos; s.moving = moving_r;
    s.homing = homing_r; s.alarm_armed = armed_r;
    s.half_period_us = armed_r ? armed_half : 32'd0; s.driver_enable = en_r;
    expected_status.push_back(s);
  endtask

  task automatic send_item(input logic [2:0] m, input logic [31:0] tg,
                           input logic [15:0] rp, input logic hf);
    int gap;
    gap = 0;
    if ($urandom_range(0, 3) == 0) gap = $urandom_range(1, 6);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= m;
    s_axis_tdata <= {7'd0, hf, rp, tg};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_status(m, tg, rp, hf);
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SPR: spr = {16'd0, v[15:0]};
      REG_CRUISE: cruise_rpm = {16'd0, v[15:0]};
      REG_START: base_rpm_r = {16'd0, v[15:0]};
      REG_ACCEL: accel = v;
      default: ;
    endcase
  endtask

  task automatic cfg_done();
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else begin
      if ($urandom_range(0, 15) == 0) stall_rx = !stall_rx;
      m_axis_tready <= stall_rx ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  always @(posedge clk) begin
    status_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_status.size() == 0) begin
        $error("result with no expectation: %h", m_axis_tdata);
        errors++;
      end else begin
        want = expected_status.pop_front();
        if (got.step_pulse !== want.step_pulse) begin
          $error("step_pulse exp %0d got %0d", want.step_pulse, got.step_pulse); errors++; end
        if (got.direction !== want.direction) begin
          $error("direction exp %0d got %0d", want.direction, got.direction); errors++; end
        if (got.position !== want.position) begin
          $error("position exp %0d got %0d", $signed(want.position), $signed(got.position));
          errors++; end
        if (got.moving !== want.moving) begin
          $error("moving exp %0d got %0d", want.moving, got.moving); errors++; end
        if (got.homing !== want.homing) begin
          $error("homing exp %0d got %0d", want.homing, got.homing); errors++; end
        if (got.alarm_armed !== want.alarm_armed) begin
          $error("alarm_armed exp %0d got %0d", want.alarm_armed, got.alarm_armed); errors++; end
        if (got.half_period_us !== want.half_period_us) begin
          $error("half_period_us exp %0d got %0d", want.half_period_us, got.half_period_us);
          errors++; end
        if (got.driver_enable !== want.driver_enable) begin
          $error("driver_enable exp %0d got %0d", want.driver_enable, got.driver_enable);
          errors++; end
        if (got.at_target !== want.at_target) begin
          $error("at_target exp %0d got %0d", want.at_target, got.at_target); errors++; end
        if (got.rejected !== want.rejected) begin
          $error("rejected exp %0d got %0d", want.rejected, got.rejected); errors++; end
      end
    end
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic row_t mk(input logic [2:0] m, input logic [31:0] tg,
                              input logic [15:0] rp, input logic hf);
    row_t r;
    r.mode = m; r.target = tg; r.rpm = rp; r.fwd = hf; r.known = 1'b0; r.res = '0;
    return r;
  endfunction

  task automatic random_phase(input int n);
    int k, burst, j;
    logic [31:0] tg;
    logic [15:0] rp;
    k = 0;
    while (k < n) begin
      burst = $urandom_range(1, 12);
      for (j = 0; j < burst && k < n; j++) begin
        case ($urandom_range(0, 19))
          0, 1, 2: begin
            // mostly short moves so that ramps complete
            tg = pos + 32'($urandom_range(0, 60)) - 32'd30;
            if ($urandom_range(0, 9) == 0) tg = $urandom;
            rp = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
            send_item(MODE_MOVE, tg, rp, 1'($urandom_range(0, 1)));
          end
          3: send_item(MODE_HOME, $urandom, 16'($urandom_range(0, 65535)),
                       1'($urandom_range(0, 1)));
          4: send_item(MODE_STOP, $urandom, 16'($urandom), 1'($urandom_range(0, 1)));
          5: send_item(MODE_SETPOS, $urandom, 16'($urandom), 1'($urandom_range(0, 1)));
          6: send_item(3'($urandom_range(5, 7)), $urandom, 16'($urandom),
                       1'($urandom_range(0, 1)));
          default: send_item(MODE_TICK, $urandom, 16'($urandom), 1'($urandom_range(0, 1)));
        endcase
        k++;
      end
      pause($urandom_range(0, 20));
    end
  endtask

  row_t dir_rows[$];
  initial begin
    status_t r0;
    int i, w;
    spr = 32'd200; cruise_rpm = 32'd300; base_rpm_r = 32'd60; accel = 32'd400;
    pos = '0; done_n = '0; total_n = '0; ch = '0; sh = '0; ramp = '0; armed_half = '0;
    fwd_r = 1'b0; homing_r = 1'b0; moving_r = 1'b0; en_r = 1'b0; armed_r = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // after reset: idle tick reports all zeros
    dir_rows.push_back(mk(MODE_TICK, 32'd0, 16'd0, 1'b0));
    dir_rows[0].known = 1'b1; dir_rows[0].res = '0;
    // move to current position while idle gives at_target
    dir_rows.push_back(mk(MODE_MOVE, 32'd0, 16'd0, 1'b0));
    r0 = '0; r0.at_target = 1'b1; dir_rows[1].known = 1'b1; dir_rows[1].res = r0;
    dir_rows.push_back(mk(MODE_MOVE, 32'd6, 16'd0, 1'b0));
    dir_rows.push_back(mk(MODE_TICK, 32'd0, 16'd0, 1'b0));
    dir_rows.push_back(mk(MODE_MOVE, 32'd9, 16'd65535, 1'b0));   // retarget
    dir_rows.push_back(mk(MODE_MOVE, 32'hFFFFFFF0, 16'd10, 1'b0)); // reversing
    dir_rows.push_back(mk(MODE_MOVE, 32'd1, 16'd10, 1'b0));       // same pos while moving
    for (i = 0; i < 8; i++) dir_rows.push_back(mk(MODE_TICK, 32'd0, 16'd0, 1'b0));
    dir_rows.push_back(mk(MODE_HOME, 32'd0, 16'd0, 1'b1));
    dir_rows.push_back(mk(MODE_TICK, 32'd0, 16'd0, 1'b0));
    dir_rows.push_back(mk(MODE_HOME, 32'd0, 16'd65535, 1'b0));    // homing while moving
    dir_rows.push_back(mk(MODE_TICK, 32'hFFFFFFFF, 16'hFFFF, 1'b1));
    dir_rows.push_back(mk(MODE_STOP, 32'd0, 16'd0, 1'b0));
    dir_rows.push_back(mk(MODE_SETPOS, 32'h80000000, 16'd0, 1'b0));
    dir_rows.push_back(mk(MODE_MOVE, 32'h00000000, 16'd1, 1'b0)); // largest distance
    dir_rows.push_back(mk(MODE_TICK, 32'd0, 16'd0, 1'b0));
    dir_rows.push_back(mk(MODE_STOP, 32'd0, 16'd0, 1'b0));
    dir_rows.push_back(mk(MODE_SETPOS, 32'h7FFFFFFF, 16'd0, 1'b0));
    dir_rows.push_back(mk(3'd7, 32'hFFFFFFFF, 16'hFFFF, 1'b1));
    dir_rows.push_back(mk(3'd5, 32'd0, 16'd0, 1'b0));
    for (i = 0; i < dir_rows.size(); i++) begin
      send_item(dir_rows[i].mode, dir_rows[i].target, dir_rows[i].rpm, dir_rows[i].fwd);
      if (dir_rows[i].known) void'(expected_status.pop_back());
      if (dir_rows[i].known) expected_status.push_back(dir_rows[i].res);
    end
    // pause until everything is out
    drain_results();

    for (w = 0; w < 5; w++) begin
      case (w)
        0: random_phase(400);
        1: begin
          write_reg(REG_SPR, 32'd1); write_reg(REG_CRUISE, 32'd65535);
          write_reg(REG_START, 32'd1); write_reg(REG_ACCEL, 32'd0);
          cfg_done();
          random_phase(350);
        end
        2: begin
          write_reg(REG_SPR, 32'd65535); write_reg(REG_CRUISE, 32'd1);
          write_reg(REG_START, 32'd65535); write_reg(REG_ACCEL, 32'hFFFFFFFF);
          cfg_done();
          random_phase(350);
        end
        3: begin
          // upper bits of a 16-bit register write are dropped
          write_reg(REG_SPR, 32'hFFFF0000 | 32'($urandom_range(1, 65535)));
          write_reg(REG_CRUISE, 32'($urandom_range(1, 65535)));
          write_reg(REG_START, 32'($urandom_range(1, 2000)));
          write_reg(REG_ACCEL, 32'($urandom_range(1, 20)));
          cfg_done();
          random_phase(350);
        end
        default: begin
          write_reg(REG_SPR, 32'd200); write_reg(REG_CRUISE, 32'd3000);
          write_reg(REG_START, 32'd30); write_reg(REG_ACCEL, 32'($urandom_range(2, 12)));
          cfg_done();
          random_phase(450);
        end
      endcase
      drain_results();
    end

    if (errors == 0 && expected_status.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

FILE: sim.f
src/sttsg_pkg.sv
src/sttsg_div.sv
src/sttsg_ctrl.sv
src/sttsg_dp.sv
src/stepper_trapezoid_step_generator.sv
tb/tb_stepper_trapezoid_step_generator.sv
